FILE: hdl/vced_pkg.sv
// shared types and constants for the vibration cycle-end detector
// no dependencies; imported by vibration_cycle_end_detector

package vced_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_VOTE_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_QUIET_LIMIT    = 2'd2;

   localparam logic [3:0] WINDOW_LENGTH_RESET  = 4'd10;
   localparam logic [3:0] VOTE_THRESHOLD_RESET = 4'd4;
   localparam logic [9:0] QUIET_LIMIT_RESET    = 10'd600;

   localparam logic [3:0]  ACTIVE_SAMPLES_MAX = 4'd15;
   localparam logic [10:0] QUIET_CAP          = 11'd1024;

   // event codes
   localparam logic [1:0] EV_NONE         = 2'd0;
   localparam logic [1:0] EV_CYCLE_START  = 2'd1;
   localparam logic [1:0] EV_BACK_ACTIVE  = 2'd2;
   localparam logic [1:0] EV_CYCLE_DONE   = 2'd3;

   typedef struct packed {
      logic        decision_valid;
      logic        vibrating;
      logic [1:0]  machine_state;
      logic [1:0]  event_code;
      logic [10:0] quiet_count;
   } result_type;

endpackage

FILE: hdl/vibration_cycle_end_detector.sv
// vibration cycle-end detector: window vote, cycle state machine, output skid
// depends on vced_pkg

// Takes one active-low sensor sample per item and returns one result per item.
// One item is accepted every clock cycle while req_stall is low: the window
// counters, the vote and the cycle state machine update on the accepting
// edge, when the result lands in the output register, or in the skid entry
// if rsp_stall holds it. With one result register and one skid entry on the
// output, req_stall rises only when both hold results that rsp_stall keeps
// waiting. The user must write configuration via csr_write/csr_index/csr_data
// only while the block is idle, which it does not enforce; index 3 is ignored.
module vibration_cycle_end_detector
   import vced_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data,
   // sample items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_sensor_level,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_decision_valid,
   output logic        rsp_vibrating,
   output logic [1:0]  rsp_machine_state,
   output logic [1:0]  rsp_event_code,
   output logic [10:0] rsp_quiet_count
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_ACTIVE   = 2'd1,
      PH_WAITING  = 2'd2,
      PH_COMPLETE = 2'd3
   } phase_type;

   logic [3:0]  window_length_ff;
   logic [3:0]  vote_threshold_ff;
   logic [9:0]  quiet_limit_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  sample_index_ff, sample_index_in;
   logic [3:0]  active_samples_ff, active_samples_in;
   logic [10:0] quiet_counter_ff, quiet_counter_in;
   logic        vibration_flag_ff, vibration_flag_in;

   logic        rsp_valid_ff;
   result_type  rsp_data_ff;
   logic        skid_valid_ff;
   result_type  skid_data_ff;

   logic        accept;
   logic        out_free;
   logic [3:0]  len;
   logic [3:0]  active_inc;
   logic [4:0]  count;
   logic        close;
   logic        vib;
   logic [10:0] quiet_inc;
   logic [1:0]  event_in;
   result_type  result;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      len        = (window_length_ff == 4'd0) ? 4'd1 : window_length_ff;
      active_inc = active_samples_ff;
      if (!req_sensor_level && active_samples_ff < ACTIVE_SAMPLES_MAX) begin
         active_inc = active_samples_ff + 4'd1;
      end
      count = {1'b0, sample_index_ff} + 5'd1;
      close = count >= {1'b0, len};
      vib   = active_inc >= vote_threshold_ff;
      quiet_inc = (quiet_counter_ff < QUIET_CAP) ? quiet_counter_ff + 11'd1
                                                 : quiet_counter_ff;

      phase_in          = phase_ff;
      quiet_counter_in  = quiet_counter_ff;
      vibration_flag_in = vibration_flag_ff;
      event_in          = EV_NONE;
      sample_index_in   = count[3:0];
      active_samples_in = active_inc;

      if (close) begin
         sample_index_in   = 4'd0;
         active_samples_in = 4'd0;
         vibration_flag_in = vib;
         unique case (phase_ff)
            PH_IDLE: begin
               if (vib) begin
                  phase_in = PH_ACTIVE;
                  event_in = EV_CYCLE_START;
               end
            end
            PH_ACTIVE: begin
               if (!vib) begin
                  phase_in         = PH_WAITING;
                  quiet_counter_in = 11'd0;
               end
            end
            PH_WAITING: begin
               if (vib) begin
                  phase_in = PH_ACTIVE;
                  event_in = EV_BACK_ACTIVE;
               end else begin
                  quiet_counter_in = quiet_inc;
                  if (quiet_inc > {1'b0, quiet_limit_ff}) begin
                     phase_in = PH_COMPLETE;
                     event_in = EV_CYCLE_DONE;
                  end
               end
            end
            PH_COMPLETE: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      result.decision_valid = close;
      result.vibrating      = vibration_flag_in;
      result.machine_state  = phase_in;
      result.event_code     = event_in;
      result.quiet_count    = quiet_counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= WINDOW_LENGTH_RESET;
         vote_threshold_ff <= VOTE_THRESHOLD_RESET;
         quiet_limit_ff    <= QUIET_LIMIT_RESET;
         phase_ff          <= PH_IDLE;
         sample_index_ff   <= 4'd0;
         active_samples_ff <= 4'd0;
         quiet_counter_ff  <= 11'd0;
         vibration_flag_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_WINDOW_LENGTH:  window_length_ff  <= csr_data[3:0];
               CSR_VOTE_THRESHOLD: vote_threshold_ff <= csr_data[3:0];
               CSR_QUIET_LIMIT:    quiet_limit_ff    <= csr_data;
               default: ;
            endcase
         end

         if (accept) begin
            phase_ff          <= phase_in;
            sample_index_ff   <= sample_index_in;
            active_samples_ff <= active_samples_in;
            quiet_counter_ff  <= quiet_counter_in;
            vibration_flag_ff <= vibration_flag_in;
         end

         // output register drains from the skid entry first
         if (out_free) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               rsp_data_ff   <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= accept;
               if (accept) begin
                  rsp_data_ff <= result;
               end
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= result;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decision_valid = rsp_data_ff.decision_valid;
   assign rsp_vibrating      = rsp_data_ff.vibrating;
   assign rsp_machine_state  = rsp_data_ff.machine_state;
   assign rsp_event_code     = rsp_data_ff.event_code;
   assign rsp_quiet_count    = rsp_data_ff.quiet_count;

endmodule
